// File: rtl/core/shaf_pkg.sv
package shaf_pkg;

    localparam int unsigned SEEN_ENTRIES_DEF     = 64;
    localparam int unsigned PROMOTED_ENTRIES_DEF = 64;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SLOT_W = 32;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] decision_t;

    localparam mode_t MODE_CLASSIFY = 2'd0;
    localparam mode_t MODE_PROMOTE  = 2'd1;
    localparam mode_t MODE_CLEAR    = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_RESOURCE = 2'd1;
    localparam status_t ST_INVALID  = 2'd2;

    localparam decision_t DEC_FIRST   = 2'd0;
    localparam decision_t DEC_PROMOTE = 2'd1;
    localparam decision_t DEC_HIT     = 2'd2;

endpackage

// File: rtl/core/second_hit_admission_filter.sv
// Two-hit cache admission filter.
// Input channel (valid/ready): mode, key, slot. Output channel (valid/ready):
// status, decision, hit_slot; exactly one result beat per input beat, in order.
// Keys live in two simple dual-port RAMs with registered reads: the
// seen set and the promoted map (key plus slot). Entries fill from index 0 upward
// and are only emptied all at once, so a fill count marks the valid range.
// A classify or promote beat scans both RAMs in lockstep, one address per
// cycle, up to the larger of the two fill counts, then decides and writes
// back at most one entry. A clear or an unused mode skips the scan and goes
// straight to the decide state.
// One item is in flight at a time; the next beat is accepted once the result
// has moved into the output register, so one result may wait downstream
// while the next item is already scanning. The RAM scan loop sets the rate.
// Reset empties both stores at once (fill counts to zero) and drops any
// pending result. If the receiver stalls, the result holds in the output
// register and a finished scan waits for it before writing back.
module second_hit_admission_filter #(
    parameter int unsigned SEEN_ENTRIES     = shaf_pkg::SEEN_ENTRIES_DEF,
    parameter int unsigned PROMOTED_ENTRIES = shaf_pkg::PROMOTED_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  shaf_pkg::mode_t               mode,
    input  logic [shaf_pkg::KEY_W-1:0]    key,
    input  logic [shaf_pkg::SLOT_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output shaf_pkg::status_t             status,
    output shaf_pkg::decision_t           decision,
    output logic [shaf_pkg::SLOT_W-1:0]   hit_slot
);
    import shaf_pkg::*;

    localparam int unsigned MAX_ENTRIES =
        (SEEN_ENTRIES > PROMOTED_ENTRIES) ? SEEN_ENTRIES : PROMOTED_ENTRIES;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SA_W  = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;
    localparam int unsigned PA_W  =
        (PROMOTED_ENTRIES > 1) ? $clog2(PROMOTED_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] SEEN_MAX = CNT_W'(SEEN_ENTRIES);
    localparam logic [CNT_W-1:0] PROM_MAX = CNT_W'(PROMOTED_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

    logic [KEY_W-1:0]          seen_mem [SEEN_ENTRIES];
    logic [KEY_W+SLOT_W-1:0]   prom_mem [PROMOTED_ENTRIES];
    logic [KEY_W-1:0]          seen_rdata;
    logic [KEY_W+SLOT_W-1:0]   prom_rdata;

    state_t              state_reg;
    mode_t               mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    seen_cnt_reg;
    logic [CNT_W-1:0]    prom_cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    pend_idx_reg;
    logic                pend_reg;
    logic                seen_hit_reg;
    logic                prom_hit_reg;
    logic [SLOT_W-1:0]   found_slot_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    decision_t           decision_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;

    logic [CNT_W-1:0]    scan_limit;
    logic                issue;
    logic                out_free;
    logic                seen_match;
    logic                prom_match;
    logic                seen_wr;
    logic                prom_wr;
    status_t             status_next;
    decision_t           decision_next;
    logic [SLOT_W-1:0]   hit_slot_next;

    assign scan_limit = (seen_cnt_reg > prom_cnt_reg) ? seen_cnt_reg : prom_cnt_reg;
    assign issue      = (state_reg == S_SCAN) && (idx_reg < scan_limit);
    assign out_free   = !out_valid_reg || out_ready;
    assign seen_match = pend_reg && (pend_idx_reg < seen_cnt_reg) && (seen_rdata == key_reg);
    assign prom_match = pend_reg && (pend_idx_reg < prom_cnt_reg)
                        && (prom_rdata[KEY_W+SLOT_W-1:SLOT_W] == key_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign decision  = decision_reg;
    assign hit_slot  = hit_slot_reg;

    // result and write-back selection, used when the scan is complete
    always_comb
    begin
        status_next   = ST_OK;
        decision_next = DEC_FIRST;
        hit_slot_next = '0;
        seen_wr       = 1'b0;
        prom_wr       = 1'b0;
        case (mode_reg)
            MODE_CLASSIFY:
            begin
                if (prom_hit_reg)
                begin
                    decision_next = DEC_HIT;
                    hit_slot_next = found_slot_reg;
                end
                else if (seen_hit_reg)
                    decision_next = DEC_PROMOTE;
                else if (seen_cnt_reg < SEEN_MAX)
                    seen_wr = 1'b1;
                else
                    status_next = ST_RESOURCE;
            end
            MODE_PROMOTE:
            begin
                if (!seen_hit_reg || prom_hit_reg)
                    status_next = ST_INVALID;
                else if (prom_cnt_reg < PROM_MAX)
                    prom_wr = 1'b1;
                else
                    status_next = ST_RESOURCE;
            end
            MODE_CLEAR:
                status_next = ST_OK;
            default:
                status_next = ST_INVALID;
        endcase
    end

    always_ff @(posedge clk)
    begin
        seen_rdata <= seen_mem[idx_reg[SA_W-1:0]];
        if (state_reg == S_DECIDE && out_free && seen_wr)
            seen_mem[seen_cnt_reg[SA_W-1:0]] <= key_reg;
    end

    always_ff @(posedge clk)
    begin
        prom_rdata <= prom_mem[idx_reg[PA_W-1:0]];
        if (state_reg == S_DECIDE && out_free && prom_wr)
            prom_mem[prom_cnt_reg[PA_W-1:0]] <= {key_reg, slot_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_cnt_reg  <= '0;
            prom_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DECIDE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg     <= mode;
                        key_reg      <= key;
                        slot_reg     <= slot;
                        idx_reg      <= '0;
                        pend_reg     <= 1'b0;
                        seen_hit_reg <= 1'b0;
                        prom_hit_reg <= 1'b0;
                        if (mode == MODE_CLASSIFY || mode == MODE_PROMOTE)
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_DECIDE;
                    end
                end
                S_SCAN:
                begin
                    // one address issued per cycle, compared the next
                    pend_reg     <= issue;
                    pend_idx_reg <= idx_reg;
                    if (issue)
                        idx_reg <= idx_reg + 1'b1;
                    if (seen_match)
                        seen_hit_reg <= 1'b1;
                    if (prom_match && !prom_hit_reg)
                    begin
                        prom_hit_reg   <= 1'b1;
                        found_slot_reg <= prom_rdata[SLOT_W-1:0];
                    end
                    if (!issue && !pend_reg)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        status_reg    <= status_next;
                        decision_reg  <= decision_next;
                        hit_slot_reg  <= hit_slot_next;
                        if (mode_reg == MODE_CLEAR)
                        begin
                            seen_cnt_reg <= '0;
                            prom_cnt_reg <= '0;
                        end
                        if (seen_wr)
                            seen_cnt_reg <= seen_cnt_reg + 1'b1;
                        if (prom_wr)
                            prom_cnt_reg <= prom_cnt_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: bench/second_hit_admission_filter_tb.sv
`timescale 1ns / 1ps

module second_hit_admission_filter_tb;
    import shaf_pkg::*;

    localparam mode_t MODE_UNUSED = 2'd3;
    localparam int    NSEEN = SEEN_ENTRIES_DEF;
    localparam int    NPROM = PROMOTED_ENTRIES_DEF;

    typedef struct packed {
        mode_t              mode;
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
    } req_t;

    typedef struct packed {
        status_t            status;
        decision_t          decision;
        logic [SLOT_W-1:0]  hit_slot;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mode_t               mode;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot;
    logic                out_valid;
    logic                out_ready;
    status_t             status;
    decision_t           decision;
    logic [SLOT_W-1:0]   hit_slot;

    second_hit_admission_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .slot      (slot),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .decision  (decision),
        .hit_slot  (hit_slot)
    );

    // shadow copy of both stores
    logic [KEY_W-1:0]  shadow_seen_key [NSEEN];
    logic              shadow_seen_vld [NSEEN];
    logic [KEY_W-1:0]  shadow_prom_key [NPROM];
    logic [SLOT_W-1:0] shadow_prom_slot[NPROM];
    logic              shadow_prom_vld [NPROM];

    req_t     pending_reqs[$];
    verdict_t expected_verdicts[$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_cycles;
    int errors;
    int mismatches;
    int n_in;
    int n_out;
    int n_hit;
    int n_promote_dec;
    int n_resource;
    int n_invalid;
    int n_clear;
    logic in_beat;

    logic [KEY_W-1:0] key_pool[96];

    function automatic verdict_t admit_filter(req_t r);
        verdict_t v;
        int       at;
        bit       seen;
        bit       done;
        v    = '0;
        at   = -1;
        seen = 0;
        done = 0;
        for (int i = 0; i < NPROM; i++)
            if (at < 0 && shadow_prom_vld[i] && shadow_prom_key[i] == r.key)
                at = i;
        for (int i = 0; i < NSEEN; i++)
            if (shadow_seen_vld[i] && shadow_seen_key[i] == r.key)
                seen = 1;
        case (r.mode)
            MODE_CLASSIFY:
            begin
                if (at >= 0)
                begin
                    v.decision = DEC_HIT;
                    v.hit_slot = shadow_prom_slot[at];
                end
                else if (seen)
                    v.decision = DEC_PROMOTE;
                else
                begin
                    v.decision = DEC_FIRST;
                    v.status   = ST_RESOURCE;
                    for (int i = 0; i < NSEEN; i++)
                        if (!done && !shadow_seen_vld[i])
                        begin
                            shadow_seen_vld[i] = 1;
                            shadow_seen_key[i] = r.key;
                            v.status = ST_OK;
                            done = 1;
                        end
                end
            end
            MODE_PROMOTE:
            begin
                if (!seen || at >= 0)
                    v.status = ST_INVALID;
                else
                begin
                    v.status = ST_RESOURCE;
                    for (int i = 0; i < NPROM; i++)
                        if (!done && !shadow_prom_vld[i])
                        begin
                            shadow_prom_vld[i]  = 1;
                            shadow_prom_key[i]  = r.key;
                            shadow_prom_slot[i] = r.slot;
                            v.status = ST_OK;
                            done = 1;
                        end
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < NSEEN; i++) shadow_seen_vld[i] = 0;
                for (int i = 0; i < NPROM; i++) shadow_prom_vld[i] = 0;
            end
            default:
                v.status = ST_INVALID;
        endcase
        return v;
    endfunction

    task automatic push_req(mode_t m, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s);
        req_t r;
        r.mode = m;
        r.key  = k;
        r.slot = s;
        pending_reqs.push_back(r);
    endtask

    task automatic refill_pool();
        foreach (key_pool[i]) key_pool[i] = $urandom;
    endtask

    // mostly keys from a small pool so keys repeat and stores fill up
    task automatic push_random(int count);
        int               sel;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(999);
            k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(95)];
            if (sel < 8)
            begin
                push_req(MODE_CLEAR, $urandom, $urandom);
                refill_pool();
            end
            else if (sel < 16)
                push_req(MODE_UNUSED, k, $urandom);
            else if (sel < 600)
                push_req(MODE_CLASSIFY, k, $urandom);
            else
                push_req(MODE_PROMOTE, k, $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("second_hit_admission_filter regression: fail");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_beat)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    mode     <= r.mode;
                    key      <= r.key;
                    slot     <= r.slot;
                end
                else
                    in_valid <= 1'b0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready   <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        in_beat <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_out++;
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected result beat: status %0d decision %0d slot %h",
                                 status, decision, hit_slot);
                    mismatches++;
                end
                else
                begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if (e.status !== status || e.decision !== decision
                        || e.hit_slot !== hit_slot)
                    begin
                        errors++;
                        if (mismatches < 10)
                            $display("result %0d mismatch: exp %0d/%0d/%h got %0d/%0d/%h",
                                     n_out, e.status, e.decision, e.hit_slot,
                                     status, decision, hit_slot);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                req_t     r;
                verdict_t v;
                r.mode = mode;
                r.key  = key;
                r.slot = slot;
                v = admit_filter(r);
                n_in++;
                if (r.mode == MODE_CLEAR) n_clear++;
                if (v.status == ST_RESOURCE) n_resource++;
                if (v.status == ST_INVALID) n_invalid++;
                if (v.status == ST_OK && r.mode == MODE_CLASSIFY && v.decision == DEC_HIT)
                    n_hit++;
                if (v.status == ST_OK && v.decision == DEC_PROMOTE) n_promote_dec++;
                expected_verdicts.push_back(v);
            end
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        mode = MODE_CLASSIFY;
        key = '0;
        slot = '0;
        in_beat = 0;
        hold_cycles = 0;
        errors = 0;
        mismatches = 0;
        n_in = 0; n_out = 0; n_hit = 0; n_promote_dec = 0;
        n_resource = 0; n_invalid = 0; n_clear = 0;
        snd_idle_pct = 29;
        rcv_idle_pct = 83;
        for (int i = 0; i < NSEEN; i++) shadow_seen_vld[i] = 0;
        for (int i = 0; i < NPROM; i++) shadow_prom_vld[i] = 0;
        refill_pool();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: first, second, promote, hit, bad promotes, unused mode, clear
        push_req(MODE_CLASSIFY, 32'h0, 32'h0);
        push_req(MODE_CLASSIFY, 32'h0, 32'hFFFF_FFFF);
        push_req(MODE_PROMOTE,  32'h0, 32'hFFFF_FFFF);
        push_req(MODE_CLASSIFY, 32'h0, 32'h0);
        push_req(MODE_PROMOTE,  32'h0, 32'h1234_5678);
        push_req(MODE_PROMOTE,  32'hFFFF_FFFF, 32'h1);
        push_req(MODE_CLASSIFY, 32'hFFFF_FFFF, 32'h0);
        push_req(MODE_PROMOTE,  32'hFFFF_FFFF, 32'h0);
        push_req(MODE_CLASSIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_CLEAR,    32'h0, 32'h0);
        push_req(MODE_CLASSIFY, 32'h0, 32'h0);
        push_req(MODE_PROMOTE,  32'hFFFF_FFFF, 32'h0);
        push_req(MODE_CLEAR,    32'h0, 32'h0);
        wait_drained();

        // fill both stores to the brim, overflow the seen store, then classify a promoted key
        for (int i = 0; i < NSEEN; i++) push_req(MODE_CLASSIFY, 32'hA000_0000 + i, '0);
        push_req(MODE_CLASSIFY, 32'hB000_0000, '0);
        for (int i = 0; i < NPROM; i++) push_req(MODE_PROMOTE, 32'hA000_0000 + i, 1000 + i);
        push_req(MODE_CLASSIFY, 32'hA000_003F, '0);
        push_req(MODE_CLEAR, '0, '0);
        wait_drained();

        push_random(520);
        wait_drained();

        snd_idle_pct = 83;
        rcv_idle_pct = 29;
        push_random(260);
        // sender pauses until every result is back
        wait_drained();
        push_random(260);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        @(negedge clk);
        hold_cycles = 400;
        push_random(520);
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d items, %0d results: %0d hits, %0d promote decisions, %0d clears",
                 n_in, n_out, n_hit, n_promote_dec, n_clear);
        $display("%0d store-full results and %0d invalid requests exercised",
                 n_resource, n_invalid);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("second_hit_admission_filter regression: pass");
        else
            $display("second_hit_admission_filter regression: fail");
        $finish;
    end

endmodule

// File: second_hit_admission_filter.f
rtl/core/shaf_pkg.sv
rtl/core/second_hit_admission_filter.sv
bench/second_hit_admission_filter_tb.sv
